@@ src/u2da_pkg.sv @@
package u2da_pkg;

   localparam int VALUE_BITS = 64;
   localparam int MAX_DIGITS = 20;
   localparam int DIGIT_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int CHAR_W     = 6;
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);

   localparam logic [CHAR_W-1:0]    ASCII_ZERO = CHAR_W'(48);
   localparam logic [COUNT_W-1:0]   DIGITS_MAX = COUNT_W'(MAX_DIGITS);
   localparam logic [BIT_CNT_W-1:0] BITS_LAST  = BIT_CNT_W'(VALUE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // control shared by every cell of the row
   typedef struct packed {
      logic clear;
      logic conv;
      logic emit;
   } cell_ctrl_type;

endpackage

@@ src/uint64_to_decimal_ascii.sv @@
// Converts one unsigned binary value per transfer into its decimal ASCII digits, most
// significant first, without leading zeros (zero gives a single '0'). Each digit leaves
// as its own transfer together with the total digit count and a last-digit flag. The
// conversion runs through a row of BCD digit cells, one input bit per cycle
// (double dabble), and then the digits are sent. One item is handled at a time:
// req_stall is high from the accepting edge until the last digit has been taken.
module uint64_to_decimal_ascii
   import u2da_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [63:0]         req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CHAR_W-1:0]   rsp_digit_char,
   output logic [COUNT_W-1:0]  rsp_digit_count,
   output logic                rsp_last_digit
);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      idx_ff, idx_in;
   cell_ctrl_type           ctrl;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    last;
   logic [IDX_W-1:0]        top_idx;

   logic [DIGIT_W-1:0]      digits [MAX_DIGITS];
   logic                    bits   [MAX_DIGITS];

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      logic                bit_w;
      logic [DIGIT_W-1:0]  dig_w;
      if (i == 0) begin : g_first
         assign bit_w = val_ff[VALUE_BITS-1];
         assign dig_w = '0;
      end else begin : g_rest
         assign bit_w = bits[i-1];
         assign dig_w = digits[i-1];
      end
      u2da_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .bit_in   (bit_w),
         .digit_in (dig_w),
         .digit    (digits[i]),
         .bit_out  (bits[i])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // digits move up one cell per transfer, so the next one always sits in cell count - 1
   assign top_idx         = IDX_W'(count_ff - COUNT_W'(1));
   assign last            = (idx_ff == count_ff - COUNT_W'(1));
   assign rsp_digit_char  = ASCII_ZERO + CHAR_W'(digits[top_idx]);
   assign rsp_digit_count = count_ff;
   assign rsp_last_digit  = last;

   always_comb begin
      state_in   = state_ff;
      val_in     = val_ff;
      bit_cnt_in = bit_cnt_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               val_in     = req_value[VALUE_BITS-1:0];
               bit_cnt_in = '0;
               count_in   = COUNT_W'(1);
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // the value grows by at most one digit per shift, so count trails by one
            if (count_ff < DIGITS_MAX && digits[IDX_W'(count_ff)] != '0) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (bit_cnt_ff != BITS_LAST) begin
               ctrl.conv  = 1'b1;
               val_in     = val_ff << 1;
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               ctrl.emit = 1'b1;
               idx_in    = idx_ff + COUNT_W'(1);
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff     <= val_in;
      bit_cnt_ff <= bit_cnt_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
   end

endmodule

@@ src/u2da_cell.sv @@
module u2da_cell
   import u2da_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                bit_in,
   input  logic [DIGIT_W-1:0]  digit_in,
   output logic [DIGIT_W-1:0]  digit,
   output logic                bit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in_w;
   logic [DIGIT_W-1:0] adj;

   // add three before the doubling when the digit would overflow past nine
   assign adj     = (digit_ff >= DIGIT_W'(5)) ? digit_ff + DIGIT_W'(3) : digit_ff;
   assign bit_out = adj[DIGIT_W-1];
   assign digit   = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in_w = '0;
      end else if (ctrl.conv) begin
         digit_in_w = {adj[DIGIT_W-2:0], bit_in};
      end else if (ctrl.emit) begin
         digit_in_w = digit_in;
      end else begin
         digit_in_w = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

endmodule
